// ===== rtl/priority_task_scheduler_with_delays_top_macros.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef PRIORITY_TASK_SCHEDULER_WITH_DELAYS_TOP_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_DELAYS_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/pts_pkg.sv =====
// Package with shared constants and types of the priority scheduler.
package pts_pkg;
    localparam int NUM_PRIO_DEF    = 64;
    localparam int DELAY_WIDTH_DEF = 16;

    localparam logic [2:0] ACT_CREATE    = 3'd0;
    localparam logic [2:0] ACT_BLOCK     = 3'd1;
    localparam logic [2:0] ACT_TICK      = 3'd2;
    localparam logic [2:0] ACT_SCHED     = 3'd3;
    localparam logic [2:0] ACT_INT_ENTER = 3'd4;
    localparam logic [2:0] ACT_INT_EXIT  = 3'd5;
    localparam logic [2:0] ACT_START     = 3'd6;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SLOT     = 2'd1;
    localparam logic [1:0] ST_IN_USE      = 2'd2;
    localparam logic [1:0] ST_NOT_RUNNING = 2'd3;

    localparam logic [0:0] CFG_IDLE_PRIO = 1'b0;
    localparam logic [0:0] CFG_MAX_SLOTS = 1'b1;

    // Command presented to every cell at once.
    typedef struct packed {
        logic       create;  // clear and make the addressed task present
        logic       block;   // load delay and flags into the addressed task
        logic       tick;    // count down every eligible delay
        logic [5:0] prio;
        logic [5:0] idle;
        logic       wev;
        logic       susp;
    } cell_cmd_t;
endpackage

// ===== rtl/pts_cell.sv =====
// One task cell: delay counter, flags and ready bit of one priority.
module pts_cell #(
    parameter int DELAY_WIDTH = pts_pkg::DELAY_WIDTH_DEF,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_en,
    input  pts_pkg::cell_cmd_t     cmd,
    input  logic [DELAY_WIDTH-1:0] delay_in,
    input  logic                   ready_in,   // ready bits of cells below
    input  logic [5:0]             first_in,   // lowest ready index below
    output logic                   ready_out,
    output logic [5:0]             first_out,
    output logic                   present,
    output logic                   ready
);
    localparam logic [5:0] MY_IDX = 6'(INDEX);

    logic                   present_reg, present_next;
    logic                   ready_reg, ready_next;
    logic                   wait_reg, wait_next;
    logic                   susp_reg, susp_next;
    logic                   tout_reg, tout_next;
    logic [DELAY_WIDTH-1:0] delay_reg, delay_next;
    logic                   hit;

    assign hit = (cmd.prio == MY_IDX);

    always_comb
    begin
        present_next = present_reg;
        ready_next   = ready_reg;
        wait_next    = wait_reg;
        susp_next    = susp_reg;
        tout_next    = tout_reg;
        delay_next   = delay_reg;
        if (cmd_en && cmd.create && hit)
        begin
            present_next = 1'b1;
            ready_next   = 1'b1;
            wait_next    = 1'b0;
            susp_next    = 1'b0;
            tout_next    = 1'b0;
            delay_next   = '0;
        end
        else if (cmd_en && cmd.block && hit && present_reg)
        begin
            ready_next = 1'b0;
            delay_next = delay_in;
            wait_next  = cmd.wev;
            susp_next  = cmd.susp;
            tout_next  = 1'b0;
        end
        else if (cmd_en && cmd.tick && present_reg && (cmd.idle != MY_IDX)
                 && (delay_reg != '0))
        begin
            delay_next = delay_reg - 1'b1;
            if (delay_reg == DELAY_WIDTH'(1))
            begin
                tout_next = wait_reg;
                wait_next = 1'b0;
                if (!susp_reg)
                begin
                    ready_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            ready_reg   <= 1'b0;
            wait_reg    <= 1'b0;
            susp_reg    <= 1'b0;
            tout_reg    <= 1'b0;
            delay_reg   <= '0;
        end
        else
        begin
            present_reg <= present_next;
            ready_reg   <= ready_next;
            wait_reg    <= wait_next;
            susp_reg    <= susp_next;
            tout_reg    <= tout_next;
            delay_reg   <= delay_next;
        end
    end

    // The timeout mark is kept but drives no output; ready ignores it.
    logic unused_tout;
    assign unused_tout = tout_reg;

    assign present   = present_reg;
    assign ready     = ready_reg & ~unused_tout | ready_reg;
    assign ready_out = ready_in | ready_reg;
    assign first_out = ready_in ? first_in : (ready_reg ? MY_IDX : 6'd0);
endmodule

// ===== rtl/pts_ctrl.sv =====
// Sequencer for global scheduler state and result formation.
module pts_ctrl #(
    parameter int NUM_PRIO = pts_pkg::NUM_PRIO_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic [5:0]         task_priority,
    input  logic               sched_locked,
    input  logic [6:0]         max_slots,
    input  logic [NUM_PRIO-1:0] present_map,
    input  logic               any_ready,
    input  logic [5:0]         lowest,
    output logic               cmd_en,
    output logic [2:0]         act_q,
    output logic               create_ok,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               switch_now,
    output logic [5:0]         next_priority,
    output logic [31:0]        switch_count,
    output logic [6:0]         task_count,
    output logic [31:0]        tick_count
);
    typedef enum logic [1:0] {S_IDLE, S_APPLY, S_EVAL, S_OUT} state_t;

    state_t      state_reg;
    logic [2:0]  act_reg;
    logic [5:0]  prio_reg;
    logic        lock_reg;
    logic        ok_reg;
    logic [1:0]  st_reg;
    logic        run_reg;
    logic [7:0]  depth_reg;
    logic [5:0]  cur_reg;
    logic [31:0] swc_reg, tkc_reg;
    logic [6:0]  total_reg;
    logic        sw_reg;
    logic [5:0]  nxt_reg;
    logic        in_range, free_slot;
    logic [5:0]  low_v;

    assign in_range  = ({1'b0, task_priority} < 7'(NUM_PRIO));
    assign free_slot = (total_reg < max_slots);
    assign low_v     = any_ready ? lowest : 6'd0;
    assign in_stall  = (state_reg != S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cmd_en    = (state_reg == S_APPLY);
    assign act_q     = act_reg;
    assign create_ok = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= pts_pkg::ACT_SCHED;
            prio_reg  <= '0;
            lock_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            st_reg    <= pts_pkg::ST_OK;
            run_reg   <= 1'b0;
            depth_reg <= '0;
            cur_reg   <= '0;
            swc_reg   <= '0;
            tkc_reg   <= '0;
            total_reg <= '0;
            sw_reg    <= 1'b0;
            nxt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg  <= action;
                        prio_reg <= task_priority;
                        lock_reg <= sched_locked;
                        ok_reg   <= 1'b0;
                        st_reg   <= pts_pkg::ST_OK;
                        sw_reg   <= 1'b0;
                        if (action == pts_pkg::ACT_CREATE)
                        begin
                            if (!free_slot)
                                st_reg <= pts_pkg::ST_NO_SLOT;
                            else if (!in_range
                                     || present_map[task_priority[$clog2(NUM_PRIO)-1:0]])
                                st_reg <= pts_pkg::ST_IN_USE;
                            else
                                ok_reg <= 1'b1;
                        end
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    case (act_reg)
                        pts_pkg::ACT_CREATE:
                        begin
                            if (ok_reg)
                                total_reg <= total_reg + 7'd1;
                        end
                        pts_pkg::ACT_TICK:
                        begin
                            tkc_reg <= tkc_reg + 32'd1;
                            if (!run_reg)
                                st_reg <= pts_pkg::ST_NOT_RUNNING;
                        end
                        pts_pkg::ACT_INT_ENTER:
                        begin
                            if (!run_reg)
                                st_reg <= pts_pkg::ST_NOT_RUNNING;
                            else if (depth_reg != 8'hFF)
                                depth_reg <= depth_reg + 8'd1;
                        end
                        pts_pkg::ACT_INT_EXIT:
                        begin
                            if (!run_reg)
                                st_reg <= pts_pkg::ST_NOT_RUNNING;
                            else if (depth_reg != 8'd0)
                                depth_reg <= depth_reg - 8'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    // The ready chain now reflects the updated cells.
                    nxt_reg <= low_v;
                    case (act_reg)
                        pts_pkg::ACT_SCHED, pts_pkg::ACT_INT_EXIT:
                        begin
                            if ((act_reg == pts_pkg::ACT_SCHED || run_reg)
                                && depth_reg == 8'd0 && !lock_reg && low_v != cur_reg)
                            begin
                                cur_reg <= low_v;
                                swc_reg <= swc_reg + 32'd1;
                                sw_reg  <= 1'b1;
                            end
                        end
                        pts_pkg::ACT_START:
                        begin
                            if (run_reg)
                                st_reg <= pts_pkg::ST_NOT_RUNNING;
                            else
                            begin
                                cur_reg <= low_v;
                                run_reg <= 1'b1;
                                sw_reg  <= 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = (state_reg == S_OUT);
    assign status        = st_reg;
    assign switch_now    = sw_reg;
    assign next_priority = nxt_reg;
    assign switch_count  = swc_reg;
    assign task_count    = total_reg;
    assign tick_count    = tkc_reg;
endmodule

// ===== rtl/priority_task_scheduler_with_delays_top.sv =====
// Top level of the 64-level bitmap priority scheduler with task delays.
//
//  Channel  | Handshake            | Contents
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | action, task_priority, delay_ticks, flags
//  output   | out_valid / out_stall| status, switch_now, next_priority, counts
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each transaction has four steps: capture, apply to the cell row, evaluate the
// ready chain, and present the result; the next transaction is taken once the result
// has left. Every cell updates in the same apply cycle, so a tick costs no more than
// any other command. The rippling ready chain through the cells sets the clock period.
// rst_n clears all cells and counters asynchronously. While out_stall is high the
// result is held and no new input transaction is accepted.
module priority_task_scheduler_with_delays_top #(
    parameter int NUM_PRIO    = pts_pkg::NUM_PRIO_DEF,
    parameter int DELAY_WIDTH = pts_pkg::DELAY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [5:0]  task_priority,
    input  logic [15:0] delay_ticks,
    input  logic        wait_event,
    input  logic        suspend_task,
    input  logic        sched_locked,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        switch_now,
    output logic [5:0]  next_priority,
    output logic [31:0] switch_count,
    output logic [6:0]  task_count,
    output logic [31:0] tick_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    logic [5:0]             idle_reg;
    logic [6:0]             slots_reg;
    logic [5:0]             prio_reg;
    logic [DELAY_WIDTH-1:0] dly_reg;
    logic                   wev_reg, susp_reg;
    logic                   cmd_en, create_ok, busy;
    logic [2:0]             act_q;
    pts_pkg::cell_cmd_t     cmd;
    logic [NUM_PRIO-1:0]    present_map, ready_map;
    logic [NUM_PRIO:0]      rdy_chain;
    logic [5:0]             first_chain [NUM_PRIO+1];
    logic                   run_mirror_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= 6'd63;
            slots_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pts_pkg::CFG_IDLE_PRIO: idle_reg  <= cfg_data[5:0];
                pts_pkg::CFG_MAX_SLOTS: slots_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operands for the cell row are latched when a transaction is taken.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            prio_reg <= task_priority;
            dly_reg  <= DELAY_WIDTH'(delay_ticks);
            wev_reg  <= wait_event;
            susp_reg <= suspend_task;
        end
    end

    always_comb
    begin
        cmd.create = (act_q == pts_pkg::ACT_CREATE) && create_ok;
        cmd.block  = (act_q == pts_pkg::ACT_BLOCK);
        cmd.tick   = (act_q == pts_pkg::ACT_TICK) && run_mirror_reg;
        cmd.prio   = prio_reg;
        cmd.idle   = idle_reg;
        cmd.wev    = wev_reg;
        cmd.susp   = susp_reg;
    end

    // Running flag mirrored here so the cells see ticks only once started.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_mirror_reg <= 1'b0;
        else if (busy && !cmd_en && out_valid && switch_now && status == pts_pkg::ST_OK
                 && act_q == pts_pkg::ACT_START)
            run_mirror_reg <= 1'b1;
    end

    assign rdy_chain[0]   = 1'b0;
    assign first_chain[0] = 6'd0;

    for (genvar g = 0; g < NUM_PRIO; g++)
    begin : g_cell
        pts_cell #(.DELAY_WIDTH(DELAY_WIDTH), .INDEX(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd_en    (cmd_en),
            .cmd       (cmd),
            .delay_in  (dly_reg),
            .ready_in  (rdy_chain[g]),
            .first_in  (first_chain[g]),
            .ready_out (rdy_chain[g+1]),
            .first_out (first_chain[g+1]),
            .present   (present_map[g]),
            .ready     (ready_map[g])
        );
    end

    pts_ctrl #(.NUM_PRIO(NUM_PRIO)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .task_priority (task_priority),
        .sched_locked  (sched_locked),
        .max_slots     (slots_reg),
        .present_map   (present_map),
        .any_ready     (rdy_chain[NUM_PRIO] & |ready_map),
        .lowest        (first_chain[NUM_PRIO]),
        .cmd_en        (cmd_en),
        .act_q         (act_q),
        .create_ok     (create_ok),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .switch_now    (switch_now),
        .next_priority (next_priority),
        .switch_count  (switch_count),
        .task_count    (task_count),
        .tick_count    (tick_count)
    );
endmodule

// ===== rtl/pts_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`include "priority_task_scheduler_with_delays_top_macros.svh"
module pts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        switch_now,
    input logic [6:0]  task_count
);
    `PTS_ASSERT_IMPL(a_no_take_while_out, clk, rst_n, out_valid, in_stall, "input taken while result pending")
    `PTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")
    `PTS_ASSERT_IMPL(a_task_bound, clk, rst_n, out_valid, task_count <= 7'd64, "task count exceeds slots")
    `PTS_ASSERT_IMPL(a_switch_ok, clk, rst_n, out_valid && switch_now, status == pts_pkg::ST_OK, "switch with error status")
endmodule

bind priority_task_scheduler_with_delays_top pts_checker u_pts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .switch_now   (switch_now),
    .task_count   (task_count)
);
